// ----- hw/rtl/sha512_pkg.sv -----
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, constants and the rotate function of the SHA-512 engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned ROUND_COUNT_DEF = 80;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  // word source for a schedule push
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_LASTW,
    SRC_ZERO,
    SRC_LEN
  } push_src_t;

  typedef struct packed {
    logic      push;
    push_src_t src;
    logic      add_len;
    logic      load;
    logic      round;
    logic      fold;
    logic      emit;
    logic      clear;
  } cmd_t;

  typedef struct packed {
    logic [3:0] word_position;
    logic       rounds_done;
    logic       emit_done;
  } status_t;

  localparam logic [63:0] INIT_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- hw/rtl/sha512_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha512_ctrl
// Sequencer: takes words, runs block compressions, pads, emits the digest.
// ----------------------------------------------------------------------------
module sha512_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic [3:0]            in_vb,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  input  sha512_pkg::status_t   status,
  output sha512_pkg::cmd_t      cmd
);

  sha512_pkg::state_t state, state_next;
  // pad phase: 0 = final data word, 1 = zeros, 2 = length
  logic       padding, padding_next;
  logic [1:0] pad_phase, pad_phase_next;
  logic       full_last, full_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha512_pkg::ST_IDLE;
      padding   <= 1'b0;
      pad_phase <= 2'd0;
      full_last <= 1'b0;
    end else begin
      state     <= state_next;
      padding   <= padding_next;
      pad_phase <= pad_phase_next;
      full_last <= full_last_next;
    end
  end

  always_comb begin
    state_next     = state;
    padding_next   = padding;
    pad_phase_next = pad_phase;
    full_last_next = full_last;
    cmd            = '0;
    cmd.src        = sha512_pkg::SRC_DATA;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state)
      sha512_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.add_len = 1'b1;
          if (!in_last) begin
            cmd.push = 1'b1;
            if (status.word_position == 4'd15) state_next = sha512_pkg::ST_LOAD;
          end else begin
            // full last word pushed as is, the 0x80 word follows
            full_last_next = (in_vb >= 4'd8);
            padding_next   = 1'b1;
            pad_phase_next = 2'd0;
            state_next     = sha512_pkg::ST_PAD;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        cmd.push = 1'b1;
        case (pad_phase)
          2'd0: begin
            cmd.src = full_last ? sha512_pkg::SRC_DATA : sha512_pkg::SRC_LASTW;
            if (full_last) full_last_next = 1'b0;
            else pad_phase_next = 2'd1;
          end
          2'd1: begin
            cmd.src = sha512_pkg::SRC_ZERO;
          end
          default: begin
            cmd.src = sha512_pkg::SRC_LEN;
          end
        endcase
        if (status.word_position == 4'd15) state_next = sha512_pkg::ST_LOAD;
        else if (pad_phase == 2'd1 && status.word_position == 4'd14)
          pad_phase_next = 2'd2;
      end
      sha512_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = sha512_pkg::ST_ROUND;
      end
      sha512_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.rounds_done) state_next = sha512_pkg::ST_FOLD;
      end
      sha512_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!padding) state_next = sha512_pkg::ST_IDLE;
        else if (pad_phase == 2'd2 && status.word_position == 4'd0)
          state_next = sha512_pkg::ST_EMIT;
        else state_next = sha512_pkg::ST_PAD;
      end
      sha512_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit = 1'b1;
          if (status.emit_done) begin
            cmd.clear    = 1'b1;
            padding_next = 1'b0;
            state_next   = sha512_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = sha512_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/sha512_datapath.sv -----
// ----------------------------------------------------------------------------
// sha512_datapath
// Hash state, working variables, schedule window, length and round counter.
// ----------------------------------------------------------------------------
module sha512_datapath #(
  parameter int unsigned ROUND_COUNT = sha512_pkg::ROUND_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sha512_pkg::in_item_t  in_item,
  input  sha512_pkg::cmd_t      cmd,
  output sha512_pkg::status_t   status,
  output sha512_pkg::out_item_t out_item
);

  localparam int unsigned RW = $clog2(ROUND_COUNT);

  logic [63:0]   hash_value [8];
  logic [63:0]   v [8];
  logic [63:0]   w [16];
  logic [3:0]    word_position;
  logic [63:0]   bit_length;
  logic [RW-1:0] round_index;
  logic [63:0]   last_data;
  logic [3:0]    last_vb;
  logic [2:0]    emit_index;

  logic [3:0]  vb_sat;
  logic [63:0] push_word, pad_word, mask;
  logic [63:0] s0, s1, w_new, w_cur, t1, t2, k_cur;
  logic [3:0]  t4;

  assign vb_sat = (in_item.valid_bytes > 4'd8) ? 4'd8 : in_item.valid_bytes;
  assign mask = (last_vb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> (7'(last_vb) * 7'd8));
  assign pad_word = (last_data & mask) | (64'h80 << (7'd56 - 7'(last_vb) * 7'd8));

  // data words come straight from the input; a full last word replays from its copy
  always_comb begin
    case (cmd.src)
      sha512_pkg::SRC_DATA:  push_word = cmd.add_len ? in_item.data_word : last_data;
      sha512_pkg::SRC_LASTW: push_word = pad_word;
      sha512_pkg::SRC_ZERO:  push_word = 64'd0;
      default:               push_word = bit_length;
    endcase
  end

  assign t4 = round_index[3:0];
  assign s1 = sha512_pkg::rotr(w[t4 - 4'd2], 19) ^ sha512_pkg::rotr(w[t4 - 4'd2], 61)
              ^ (w[t4 - 4'd2] >> 6);
  assign s0 = sha512_pkg::rotr(w[t4 - 4'd15], 1) ^ sha512_pkg::rotr(w[t4 - 4'd15], 8)
              ^ (w[t4 - 4'd15] >> 7);
  assign w_new = s1 + w[t4 - 4'd7] + s0 + w[t4];
  assign w_cur = (round_index >= RW'(16)) ? w_new : w[t4];
  assign k_cur = sha512_pkg::ROUND_K[round_index];
  assign t1 = v[7] + ((v[4] & v[5]) ^ (~v[4] & v[6]))
              + (sha512_pkg::rotr(v[4], 14) ^ sha512_pkg::rotr(v[4], 18)
                 ^ sha512_pkg::rotr(v[4], 41)) + w_cur + k_cur;
  assign t2 = (sha512_pkg::rotr(v[0], 28) ^ sha512_pkg::rotr(v[0], 34)
               ^ sha512_pkg::rotr(v[0], 39))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) hash_value[i] <= sha512_pkg::INIT_HASH[i];
      word_position <= '0;
      bit_length    <= '0;
      round_index   <= '0;
      emit_index    <= '0;
      last_vb       <= '0;
    end else begin
      if (cmd.add_len) begin
        bit_length <= bit_length + (in_item.last_word ? {57'd0, vb_sat, 3'd0} : 64'd64);
        last_data  <= in_item.data_word;
        last_vb    <= in_item.last_word ? vb_sat : 4'd0;
      end
      if (cmd.push) begin
        w[word_position] <= push_word;
        word_position    <= word_position + 4'd1;
        if (cmd.src == sha512_pkg::SRC_DATA && !cmd.add_len) last_vb <= 4'd0;
      end
      if (cmd.load) begin
        for (int i = 0; i < 8; i++) v[i] <= hash_value[i];
      end
      if (cmd.round) begin
        w[t4] <= w_cur;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        round_index <= (round_index == RW'(ROUND_COUNT - 1)) ? '0 : round_index + 1'b1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hash_value[i] <= hash_value[i] + v[i];
      end
      // the eighth transfer wraps the index back to zero
      if (cmd.emit) emit_index <= emit_index + 3'd1;
      if (cmd.clear) begin
        for (int i = 0; i < 8; i++) hash_value[i] <= sha512_pkg::INIT_HASH[i];
        bit_length <= '0;
      end
    end
  end

  assign status.word_position = word_position;
  assign status.rounds_done   = (round_index == RW'(ROUND_COUNT - 1));
  assign status.emit_done     = (emit_index == 3'd7);

  assign out_item.digest_word  = hash_value[emit_index];
  assign out_item.digest_index = emit_index;
  assign out_item.digest_last  = (emit_index == 3'd7);

endmodule

// ----- hw/rtl/sha512_hash_engine_top.sv -----
// ----------------------------------------------------------------------------
// sha512_hash_engine_top
// SHA-512 engine: message words in, eight digest words out per message.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one 64-bit big-endian message word per transfer; valid_bytes
//   counts left-aligned bytes and is read only with last_word set. An empty
//   message is a single last transfer with zero bytes.
//   out channel: eight transfers per message, digest_index 0..7, digest_last
//   on the eighth.
// Timing:
//   Every sixteenth word starts a compression, during which no input is taken:
//   a load step, ROUND_COUNT rounds (one round of the shared round unit per
//   cycle) and a fold step. On the last word, padding pushes one word per
//   cycle and runs one or two compressions, then the digest is shown one
//   word per cycle while out_ready is high.
// Reset: hash state returns to the standard initial values, length and word
//   counters clear. A stalled receiver holds the current digest word; no input
//   is taken until all eight words are transferred.
// ----------------------------------------------------------------------------
module sha512_hash_engine_top #(
  parameter int unsigned ROUND_COUNT = sha512_pkg::ROUND_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha512_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha512_pkg::out_item_t out_data
);

  sha512_pkg::cmd_t    cmd;
  sha512_pkg::status_t status;

  sha512_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_word),
    .in_vb     (in_data.valid_bytes),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  sha512_datapath #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_data)
  );

  // never take input while a digest is pending
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input accepted during digest output");

  // digest_last only on the eighth word
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.digest_last == (out_data.digest_index == 3'd7)))
    else $error("digest_last misplaced");

  // a stalled digest word holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("digest word changed under stall");

endmodule
